>>> design/cst_pkg.sv
// Shared types and constants for the CSV stream tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package cst_pkg;

  // Default limit on fields in one row
  localparam int unsigned MAX_COLUMNS_DEFAULT = 1024;

  // Special characters
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_QUOTE_UNENC   = 3'd1,
    ERR_BAD_AFTER_QT  = 3'd2,
    ERR_EMPTY_LINE    = 3'd3,
    ERR_TOO_MANY      = 3'd4,
    ERR_TOO_FEW       = 3'd5,
    ERR_EOF_IN_QUOTES = 3'd6
  } err_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } cst_in_t;

  typedef struct packed {
    logic       content_valid;
    logic [7:0] content_byte;
    logic       field_done;
    logic       row_done;
    logic       stream_done;
    logic [2:0] error_code;
  } cst_out_t;

endpackage

`default_nettype wire

>>> design/cst_in_stage.sv
// Input register of the CSV tokenizer: captures one beat and holds it
// until the parser consumes it. Depends on cst_pkg.
`default_nettype none

module cst_in_stage import cst_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire cst_in_t in_data_i,
  input  wire logic    take_i,
  output logic         item_valid_o,
  output cst_in_t      item_o
);

  logic    valid_q, valid_d;
  cst_in_t data_q;
  logic    load;

  // Full and not drained this cycle: hold off the sender
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = (valid_q && !take_i) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

`default_nettype wire

>>> design/cst_parser.sv
// Parser state and next-state decode: one item per cycle while fire_i is high, result is
// combinational from the held state and the current item. Depends on cst_pkg.
`default_nettype none

module cst_parser import cst_pkg::*; #(
  parameter int unsigned MaxColumns = MAX_COLUMNS_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire cst_in_t item_i,
  output cst_out_t     result_o
);

  localparam int unsigned CntW = $clog2(MaxColumns + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxColumns);

  typedef enum logic [2:0] {
    MODE_LINE_START  = 3'd0,
    MODE_AFTER_COMMA = 3'd1,
    MODE_UNQUOTED    = 3'd2,
    MODE_IN_QUOTES   = 3'd3,
    MODE_QUOTE_SEEN  = 3'd4
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] exp_q, exp_d;
  err_e            err_q, err_d;
  logic            fin_q, fin_d;

  always_comb begin
    err_e            err_new;
    mode_e           mode_nxt;
    logic            emit;
    logic [7:0]      emit_byte;
    logic            do_field;
    logic            do_row;
    logic            do_finish;
    logic            field_ovf;
    logic            row_ok;
    logic [CntW-1:0] cnt_inc;
    logic [CntW-1:0] exp_eff;

    err_new   = ERR_NONE;
    mode_nxt  = mode_q;
    emit      = 1'b0;
    emit_byte = item_i.data_byte;
    do_field  = 1'b0;
    do_row    = 1'b0;
    do_finish = 1'b0;
    row_ok    = 1'b0;

    if (!fin_q && err_q == ERR_NONE) begin
      if (item_i.kind == KIND_END) begin
        unique case (mode_q) inside
          MODE_IN_QUOTES: err_new = ERR_EOF_IN_QUOTES;
          MODE_AFTER_COMMA, MODE_UNQUOTED, MODE_QUOTE_SEEN: begin
            do_field  = 1'b1;
            do_row    = 1'b1;
            do_finish = 1'b1;
          end
          default: do_finish = 1'b1;
        endcase
      end else begin
        unique case (mode_q)
          MODE_UNQUOTED: begin
            if (item_i.data_byte == CH_QUOTE) begin
              err_new = ERR_QUOTE_UNENC;
            end else if (item_i.data_byte == CH_COMMA) begin
              do_field = 1'b1;
              mode_nxt = MODE_AFTER_COMMA;
            end else if (item_i.data_byte == CH_NEWLINE) begin
              do_field = 1'b1;
              do_row   = 1'b1;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_IN_QUOTES: begin
            if (item_i.data_byte == CH_QUOTE) begin
              mode_nxt = MODE_QUOTE_SEEN;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_QUOTE_SEEN: begin
            if (item_i.data_byte == CH_QUOTE) begin
              emit      = 1'b1;
              emit_byte = CH_QUOTE;
              mode_nxt  = MODE_IN_QUOTES;
            end else if (item_i.data_byte == CH_COMMA) begin
              do_field = 1'b1;
              mode_nxt = MODE_AFTER_COMMA;
            end else if (item_i.data_byte == CH_NEWLINE) begin
              do_field = 1'b1;
              do_row   = 1'b1;
            end else begin
              err_new = ERR_BAD_AFTER_QT;
            end
          end
          // line start, after comma, and unused codes
          default: begin
            if (item_i.data_byte == CH_QUOTE) begin
              mode_nxt = MODE_IN_QUOTES;
            end else if (item_i.data_byte == CH_COMMA) begin
              do_field = 1'b1;
              mode_nxt = MODE_AFTER_COMMA;
            end else if (item_i.data_byte == CH_NEWLINE) begin
              if (mode_q == MODE_AFTER_COMMA) begin
                do_field = 1'b1;
                do_row   = 1'b1;
              end else begin
                err_new = ERR_EMPTY_LINE;
              end
            end else begin
              emit     = 1'b1;
              mode_nxt = MODE_UNQUOTED;
            end
          end
        endcase
      end
    end

    // Field close and row check
    field_ovf = do_field && (cnt_q >= MaxCnt);
    cnt_inc   = cnt_q + CntW'(1);
    exp_eff   = (exp_q == '0) ? cnt_inc : exp_q;
    if (field_ovf) begin
      err_new = ERR_TOO_MANY;
    end else if (do_row) begin
      if (cnt_inc > exp_eff) begin
        err_new = ERR_TOO_MANY;
      end else if (cnt_inc < exp_eff) begin
        err_new = ERR_TOO_FEW;
      end else begin
        row_ok = 1'b1;
      end
    end

    mode_d = mode_q;
    cnt_d  = cnt_q;
    exp_d  = exp_q;
    err_d  = err_q;
    fin_d  = fin_q;

    if (err_new != ERR_NONE) begin
      err_d = err_new;
    end else begin
      mode_d = mode_nxt;
      if (do_row) begin
        mode_d = MODE_LINE_START;
        cnt_d  = '0;
        exp_d  = exp_eff;
      end else if (do_field) begin
        cnt_d = cnt_inc;
      end
      // finished stays set once end of input is taken
      fin_d = fin_q || do_finish;
    end

    result_o = '0;
    result_o.error_code = err_d;
    if (err_d == ERR_NONE) begin
      result_o.content_valid = emit;
      result_o.content_byte  = emit ? emit_byte : 8'h00;
      result_o.field_done    = do_field;
      result_o.row_done      = row_ok;
      result_o.stream_done   = do_finish;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINE_START;
      cnt_q  <= '0;
      exp_q  <= '0;
      err_q  <= ERR_NONE;
      fin_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      exp_q  <= exp_d;
      err_q  <= err_d;
      fin_q  <= fin_d;
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |=> (err_q == $past(err_q)))
    else $error("sticky error changed");

  a_fin_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fin_q && err_q != ERR_NONE))
    else $error("finished with an error held");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= MaxCnt) && (exp_q <= MaxCnt))
    else $error("field count beyond column limit");

endmodule

`default_nettype wire

>>> design/csv_stream_tokenizer_core.sv
// Top level of the CSV stream tokenizer: input register, parser, result
// register. Depends on cst_pkg, cst_in_stage and cst_parser.
`default_nettype none

//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+----------------------------
//  in      | sink      | in_valid_i / in_stall_o   | cst_in_t: kind, data_byte
//  out     | source    | out_valid_o / out_stall_i | cst_out_t: content, marks, error
//
//  Every beat in gives exactly one beat out, via the input and result registers.
//  Throughput is one beat per cycle while out_stall_i is low; the per-byte decode
//  sits between the input register and the result register, updating state per beat.
//  Reset (rst_ni low, async) puts the parser at line start, clears counts,
//  errors and the finished flag. No clearing pass is needed.
//  A stalled result holds the input register; a third beat sees in_stall_o.

module csv_stream_tokenizer_core import cst_pkg::*; #(
  parameter int unsigned MaxColumns = MAX_COLUMNS_DEFAULT
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cst_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output cst_out_t      out_data_o
);

  logic     item_valid;
  cst_in_t  item;
  logic     fire;
  cst_out_t result;

  logic     out_valid_q, out_valid_d;
  cst_out_t out_q;

  // Parser consumes the held beat whenever the result slot frees up
  assign fire = item_valid && !(out_valid_q && out_stall_i);

  cst_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cst_parser #(
    .MaxColumns (MaxColumns)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  // Result register: new beat on fire, else drains when not stalled
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A row mark always comes with the mark of its last field
  a_row_has_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.row_done) |-> out_q.field_done)
    else $error("row_done without field_done");

  // Error beats carry nothing but the code
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_code != ERR_NONE) |->
      !(out_q.content_valid || out_q.field_done || out_q.row_done || out_q.stream_done))
    else $error("error beat carries content or marks");

  // Parser only advances when the result register can take the beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
